### rtl/tcrs_pkg.sv
// ============================================================================
// tcrs_pkg: shared definitions of the two-class run-queue scheduler
// Widths, operation and result codes, controller states, table entry layout
// and the queue selection helper.
// ============================================================================
package tcrs_pkg;

    localparam int MAX_TASKS = 64;
    localparam int ID_W      = $clog2(MAX_TASKS);
    localparam int CNT_W     = ID_W + 1;
    localparam int NUM_Q     = 4;
    localparam int QSEL_W    = $clog2(NUM_Q);
    localparam int QADDR_W   = QSEL_W + ID_W;
    localparam int QDEPTH    = NUM_Q * MAX_TASKS;
    localparam int PRIO_W    = 8;
    localparam int TICK_W    = 16;
    localparam int PROD_W    = TICK_W + PRIO_W;
    localparam int DCNT_W    = $clog2(PROD_W);
    localparam int CFG_IDX_W = 1;
    localparam int SEL_W     = 4;

    // Counter values on which the normal class is given the first chance.
    localparam logic [SEL_W-1:0] SEL_NORMAL_A = 4'd0;
    localparam logic [SEL_W-1:0] SEL_NORMAL_B = 4'd8;
    localparam logic [SEL_W-1:0] SEL_NORMAL_C = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_SUM    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS = 1'd1;

    localparam logic [TICK_W-1:0] SLICE_SAT       = '1;
    localparam logic [TICK_W-1:0] PRIO_SUM_RST    = 16'd1;
    localparam logic [TICK_W-1:0] SLICE_TICKS_RST = 16'd1000;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_RESUME = 2'd1,
        OP_SLEEP  = 2'd2,
        OP_SCHED  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_QUEUED = 2'd0,
        KIND_IDLE   = 2'd1,
        KIND_KEEP   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RES_WR,
        ST_SCH_UPD,
        ST_SCH_PRD,
        ST_SCH_PKD,
        ST_SCH_TRD,
        ST_SCH_CHK,
        ST_SCH_DIV,
        ST_SCH_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic              rt;
        logic [TICK_W-1:0] ticks;
    } t_task_ent;

    typedef struct packed {
        logic              valid_res;
        logic [1:0]        next_kind;
        logic [ID_W-1:0]   next_task;
        logic [TICK_W-1:0] new_slice;
        logic              error;
    } t_result;

    // Runnable queue of a class; the expired queue differs in the low bit.
    function automatic logic [QSEL_W-1:0] runnable_q(input logic rt, input logic [1:0] sw);
        return rt ? {1'b1, sw[1]} : {1'b0, sw[0]};
    endfunction

endpackage

### rtl/tcrs_in_if.sv
// ============================================================================
// tcrs_in_if: request channel of the scheduler
// Valid/ready channel that carries one scheduler operation.
// ============================================================================
interface tcrs_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [tcrs_pkg::ID_W-1:0]     task_id;
    logic [tcrs_pkg::PRIO_W-1:0]   priority_req;
    logic                          realtime_req;
    logic [tcrs_pkg::TICK_W-1:0]   remaining_ticks;
    logic                          exited;
    logic                          process_context;

    modport source(output valid, opcode, task_id, priority_req, realtime_req,
                   remaining_ticks, exited, process_context, input ready);
    modport sink(input valid, opcode, task_id, priority_req, realtime_req,
                 remaining_ticks, exited, process_context, output ready);
endinterface

### rtl/tcrs_out_if.sv
// ============================================================================
// tcrs_out_if: result channel of the scheduler
// Valid/ready channel that carries one scheduler result.
// ============================================================================
interface tcrs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          valid_res;
    logic [1:0]                    next_kind;
    logic [tcrs_pkg::ID_W-1:0]     next_task;
    logic [tcrs_pkg::TICK_W-1:0]   new_slice;
    logic                          error;

    modport source(output valid, valid_res, next_kind, next_task, new_slice, error,
                   input ready);
    modport sink(input valid, valid_res, next_kind, next_task, new_slice, error,
                 output ready);
endinterface

### rtl/tcrs_ram.sv
// ============================================================================
// tcrs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module tcrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/two_class_runqueue_scheduler_core.sv
// ============================================================================
// two_class_runqueue_scheduler_core: active/expired run-queue scheduler
// Task table and four task FIFOs held in RAM, driven by a sequencer.
// ============================================================================
//
// Channel   Direction  Handshake         Carries
// i_req     in         valid/ready       one operation: init, resume, sleep, schedule
// o_res     out        valid/ready       one result for every accepted operation
// i_cfg_*   in         write enable only priority sum and slice ticks
//
// Init and sleep go straight to the result, resume through a queue write. A
// schedule ends after the update when idle is chosen or kept, reads the table
// to keep a task, and reads the queue head, then the table, to pick a queued
// one; a fresh slice adds a write-back and the restoring divider, one quotient
// bit per cycle over 24 bits. Reset is synchronous and active low; no clearing
// pass is needed, the tick field of the table is covered by a valid bit per
// task. A stalled result sits in the output register while the next
// operation is already taken in.
module two_class_runqueue_scheduler_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcrs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tcrs_pkg::TICK_W-1:0]        i_cfg_data,
    tcrs_in_if.sink                            i_req,
    tcrs_out_if.source                         o_res
);

    // Registers
    tcrs_pkg::t_state                 r_state, n_state;
    logic [tcrs_pkg::TICK_W-1:0]      r_prio_sum, n_prio_sum;
    logic [tcrs_pkg::TICK_W-1:0]      r_slice_ticks, n_slice_ticks;
    logic [tcrs_pkg::ID_W-1:0]        r_head [tcrs_pkg::NUM_Q];
    logic [tcrs_pkg::ID_W-1:0]        n_head [tcrs_pkg::NUM_Q];
    logic [tcrs_pkg::CNT_W-1:0]       r_count [tcrs_pkg::NUM_Q];
    logic [tcrs_pkg::CNT_W-1:0]       n_count [tcrs_pkg::NUM_Q];
    logic [1:0]                       r_swap, n_swap;
    logic [tcrs_pkg::SEL_W-1:0]       r_sel_ctr, n_sel_ctr;
    logic                             r_idle_req, n_idle_req;
    logic [tcrs_pkg::ID_W-1:0]        r_cur_task, n_cur_task;
    logic                             r_cur_queued, n_cur_queued;
    logic                             r_cur_idle, n_cur_idle;
    logic                             r_cur_rt, n_cur_rt;
    logic [tcrs_pkg::MAX_TASKS-1:0]   r_tick_valid, n_tick_valid;
    logic                             r_out_valid, n_out_valid;

    // Payload registers
    logic                             r_rd_valid, n_rd_valid;
    logic [tcrs_pkg::TICK_W-1:0]      r_rem, n_rem;
    logic                             r_exited, n_exited;
    logic                             r_proc, n_proc;
    logic                             r_rt_pick, n_rt_pick;
    logic [tcrs_pkg::ID_W-1:0]        r_tid, n_tid;
    logic [tcrs_pkg::PRIO_W-1:0]      r_prio, n_prio;
    logic                             r_cls, n_cls;
    logic [tcrs_pkg::TICK_W-1:0]      r_div_rem, n_div_rem;
    logic [tcrs_pkg::PROD_W-1:0]      r_dq, n_dq;
    logic [tcrs_pkg::DCNT_W-1:0]      r_div_cnt, n_div_cnt;
    tcrs_pkg::t_result                r_res, n_res;
    tcrs_pkg::t_result                r_out, n_out;

    // Memory ports
    logic                             q_we;
    logic [tcrs_pkg::QADDR_W-1:0]     q_waddr, q_raddr;
    logic [tcrs_pkg::ID_W-1:0]        q_wdata, q_rdata;
    logic                             t_we;
    logic [tcrs_pkg::ID_W-1:0]        t_waddr, t_raddr;
    tcrs_pkg::t_task_ent              t_wdata, t_rdata;

    logic                             w_in_xfer;
    logic                             w_out_load;
    logic [tcrs_pkg::TICK_W-1:0]      w_rd_ticks;
    tcrs_pkg::t_kind                  w_kind;

    // Queue store: four FIFOs of task ids, one row of MAX_TASKS slots each.
    tcrs_ram #(
        .WIDTH (tcrs_pkg::ID_W),
        .DEPTH (tcrs_pkg::QDEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // Task table: priority, class and remaining ticks per task.
    tcrs_ram #(
        .WIDTH ($bits(tcrs_pkg::t_task_ent)),
        .DEPTH (tcrs_pkg::MAX_TASKS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign i_req.ready = (r_state == tcrs_pkg::ST_IDLE);
    assign w_in_xfer   = i_req.valid && i_req.ready;
    assign w_out_load  = (r_state == tcrs_pkg::ST_DONE) && (!r_out_valid || o_res.ready);

    // A task whose ticks were never written reads as having none left.
    assign w_rd_ticks  = r_rd_valid ? t_rdata.ticks : '0;

    assign o_res.valid     = r_out_valid;
    assign o_res.valid_res = r_out.valid_res;
    assign o_res.next_kind = r_out.next_kind;
    assign o_res.next_task = r_out.next_task;
    assign o_res.new_slice = r_out.new_slice;
    assign o_res.error     = r_out.error;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcrs_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    case (tcrs_pkg::t_op'(i_req.opcode))
                        tcrs_pkg::OP_RESUME: n_state = tcrs_pkg::ST_RES_WR;
                        tcrs_pkg::OP_SCHED:  n_state = tcrs_pkg::ST_SCH_UPD;
                        default:             n_state = tcrs_pkg::ST_DONE;
                    endcase
                end
            end
            tcrs_pkg::ST_RES_WR: n_state = tcrs_pkg::ST_DONE;
            tcrs_pkg::ST_SCH_UPD: begin
                if (w_kind == tcrs_pkg::KIND_QUEUED) begin
                    n_state = tcrs_pkg::ST_SCH_PRD;
                end else if (w_kind == tcrs_pkg::KIND_KEEP && !r_cur_idle) begin
                    n_state = tcrs_pkg::ST_SCH_TRD;
                end else begin
                    n_state = tcrs_pkg::ST_DONE;
                end
            end
            tcrs_pkg::ST_SCH_PRD: n_state = tcrs_pkg::ST_SCH_PKD;
            tcrs_pkg::ST_SCH_PKD: n_state = tcrs_pkg::ST_SCH_TRD;
            tcrs_pkg::ST_SCH_TRD: n_state = tcrs_pkg::ST_SCH_CHK;
            tcrs_pkg::ST_SCH_CHK: begin
                if (w_rd_ticks != '0) begin
                    n_state = tcrs_pkg::ST_DONE;
                end else if (r_prio_sum == '0) begin
                    n_state = tcrs_pkg::ST_SCH_WB;
                end else begin
                    n_state = tcrs_pkg::ST_SCH_DIV;
                end
            end
            tcrs_pkg::ST_SCH_DIV: begin
                if (r_div_cnt == tcrs_pkg::DCNT_W'(tcrs_pkg::PROD_W - 1)) begin
                    n_state = tcrs_pkg::ST_SCH_WB;
                end
            end
            tcrs_pkg::ST_SCH_WB: n_state = tcrs_pkg::ST_DONE;
            tcrs_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = tcrs_pkg::ST_IDLE;
                end
            end
            default: n_state = tcrs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        logic [tcrs_pkg::QSEL_W-1:0] qp;
        logic [tcrs_pkg::QSEL_W-1:0] qs;
        logic [tcrs_pkg::QSEL_W-1:0] qr;
        logic [tcrs_pkg::ID_W-1:0]   slot;
        logic [tcrs_pkg::TICK_W:0]   shifted;
        logic [tcrs_pkg::TICK_W-1:0] quo;
        logic                        ge;
        logic                        err;

        n_prio_sum    = r_prio_sum;
        n_slice_ticks = r_slice_ticks;
        n_head        = r_head;
        n_count       = r_count;
        n_swap        = r_swap;
        n_sel_ctr     = r_sel_ctr;
        n_idle_req    = r_idle_req;
        n_cur_task    = r_cur_task;
        n_cur_queued  = r_cur_queued;
        n_cur_idle    = r_cur_idle;
        n_cur_rt      = r_cur_rt;
        n_tick_valid  = r_tick_valid;
        n_out_valid   = r_out_valid;
        n_rem         = r_rem;
        n_exited      = r_exited;
        n_proc        = r_proc;
        n_rt_pick     = r_rt_pick;
        n_tid         = r_tid;
        n_prio        = r_prio;
        n_cls         = r_cls;
        n_div_rem     = r_div_rem;
        n_dq          = r_dq;
        n_div_cnt     = r_div_cnt;
        n_res         = r_res;
        n_out         = r_out;
        q_we          = 1'b0;
        q_waddr       = '0;
        q_wdata       = '0;
        q_raddr       = '0;
        t_we          = 1'b0;
        t_waddr       = '0;
        t_wdata       = '0;
        t_raddr       = r_tid;
        w_kind        = tcrs_pkg::KIND_KEEP;
        qp            = '0;
        qs            = '0;
        qr            = '0;
        slot          = '0;
        shifted       = '0;
        quo           = '0;
        ge            = 1'b0;
        err           = 1'b0;

        if (i_cfg_we) begin
            if (i_cfg_idx == tcrs_pkg::CFG_PRIO_SUM) begin
                n_prio_sum = i_cfg_data;
            end else begin
                n_slice_ticks = i_cfg_data;
            end
        end

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tcrs_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_res = '0;
                    case (tcrs_pkg::t_op'(i_req.opcode))
                        tcrs_pkg::OP_INIT: begin
                            t_we    = 1'b1;
                            t_waddr = i_req.task_id;
                            t_wdata = {i_req.priority_req, i_req.realtime_req,
                                       {tcrs_pkg::TICK_W{1'b0}}};
                            n_tick_valid[i_req.task_id] = 1'b1;
                        end
                        tcrs_pkg::OP_RESUME: begin
                            t_raddr = i_req.task_id;
                            n_tid   = i_req.task_id;
                        end
                        tcrs_pkg::OP_SLEEP: begin
                            if (r_cur_queued) begin
                                qp = tcrs_pkg::runnable_q(r_cur_rt, r_swap);
                                if (r_count[qp] == '0) begin
                                    n_res.error = 1'b1;
                                end else begin
                                    n_head[qp]  = r_head[qp] + 1'b1;
                                    n_count[qp] = r_count[qp] - 1'b1;
                                end
                                n_cur_queued = 1'b0;
                            end
                        end
                        default: begin
                            t_raddr   = r_cur_task;
                            n_rem     = i_req.remaining_ticks;
                            n_exited  = i_req.exited;
                            n_proc    = i_req.process_context;
                            n_rt_pick = !(r_sel_ctr == tcrs_pkg::SEL_NORMAL_A ||
                                          r_sel_ctr == tcrs_pkg::SEL_NORMAL_B ||
                                          r_sel_ctr == tcrs_pkg::SEL_NORMAL_C);
                            n_sel_ctr = r_sel_ctr + 1'b1;
                        end
                    endcase
                end
            end

            tcrs_pkg::ST_RES_WR: begin
                qp = tcrs_pkg::runnable_q(t_rdata.rt, r_swap);
                if (r_count[qp][tcrs_pkg::CNT_W-1]) begin
                    n_res.error = 1'b1;
                end else begin
                    slot        = r_head[qp] + r_count[qp][tcrs_pkg::ID_W-1:0];
                    q_we        = 1'b1;
                    q_waddr     = {qp, slot};
                    q_wdata     = r_tid;
                    n_count[qp] = r_count[qp] + 1'b1;
                end
            end

            tcrs_pkg::ST_SCH_UPD: begin
                // Store the timer's tick count for the outgoing task.
                if (!r_cur_idle) begin
                    t_we    = 1'b1;
                    t_waddr = r_cur_task;
                    t_wdata = {t_rdata.prio, t_rdata.rt, r_rem};
                    n_tick_valid[r_cur_task] = 1'b1;
                end
                // Requeue it: runnable if ticks remain, expired otherwise.
                if (r_cur_queued) begin
                    qp = tcrs_pkg::runnable_q(r_cur_rt, r_swap);
                    if (n_count[qp] == '0) begin
                        err = 1'b1;
                    end else begin
                        n_head[qp]  = n_head[qp] + 1'b1;
                        n_count[qp] = n_count[qp] - 1'b1;
                    end
                    qs = tcrs_pkg::runnable_q(t_rdata.rt, r_swap);
                    if (r_rem == '0) begin
                        qs[0] = ~qs[0];
                    end
                    if (n_count[qs][tcrs_pkg::CNT_W-1]) begin
                        err = 1'b1;
                    end else begin
                        slot        = n_head[qs] + n_count[qs][tcrs_pkg::ID_W-1:0];
                        q_we        = 1'b1;
                        q_waddr     = {qs, slot};
                        q_wdata     = r_cur_task;
                        n_count[qs] = n_count[qs] + 1'b1;
                    end
                end
                n_idle_req = r_idle_req | r_exited;

                // Pick order: realtime runnable, realtime expired (swap) on a realtime turn,
                // pending idle, normal runnable, normal expired (swap),
                // then idle from process context or keep from irq context.
                qr = tcrs_pkg::runnable_q(1'b1, r_swap);
                if (r_rt_pick && n_count[qr] != '0) begin
                    w_kind   = tcrs_pkg::KIND_QUEUED;
                    n_cur_rt = 1'b1;
                end else if (r_rt_pick && n_count[qr ^ 2'b01] != '0) begin
                    n_swap[1] = ~r_swap[1];
                    w_kind    = tcrs_pkg::KIND_QUEUED;
                    n_cur_rt  = 1'b1;
                end else if (n_idle_req) begin
                    n_idle_req = 1'b0;
                    w_kind     = tcrs_pkg::KIND_IDLE;
                end else if (n_count[tcrs_pkg::runnable_q(1'b0, r_swap)] != '0) begin
                    w_kind   = tcrs_pkg::KIND_QUEUED;
                    n_cur_rt = 1'b0;
                end else if (n_count[tcrs_pkg::runnable_q(1'b0, r_swap) ^ 2'b01] != '0) begin
                    n_swap[0] = ~r_swap[0];
                    w_kind    = tcrs_pkg::KIND_QUEUED;
                    n_cur_rt  = 1'b0;
                end else if (r_proc) begin
                    w_kind = tcrs_pkg::KIND_IDLE;
                end else begin
                    w_kind = tcrs_pkg::KIND_KEEP;
                end

                n_res.valid_res = 1'b1;
                n_res.next_kind = w_kind;
                n_res.error     = err;
                case (w_kind)
                    tcrs_pkg::KIND_QUEUED: begin
                        n_cur_queued = 1'b1;
                        n_cur_idle   = 1'b0;
                    end
                    tcrs_pkg::KIND_IDLE: begin
                        n_cur_task   = '0;
                        n_cur_queued = 1'b0;
                        n_cur_idle   = 1'b1;
                    end
                    default: begin
                        n_cur_queued = 1'b0;
                        if (!r_cur_idle) begin
                            n_tid           = r_cur_task;
                            n_res.next_task = r_cur_task;
                        end
                    end
                endcase
            end

            tcrs_pkg::ST_SCH_PRD: begin
                qp      = tcrs_pkg::runnable_q(r_cur_rt, r_swap);
                q_raddr = {qp, r_head[qp]};
            end

            tcrs_pkg::ST_SCH_PKD: begin
                n_tid           = q_rdata;
                n_cur_task      = q_rdata;
                n_res.next_task = q_rdata;
            end

            tcrs_pkg::ST_SCH_TRD: begin
                t_raddr = r_tid;
            end

            tcrs_pkg::ST_SCH_CHK: begin
                n_prio    = t_rdata.prio;
                n_cls     = t_rdata.rt;
                n_dq      = {{tcrs_pkg::PRIO_W{1'b0}}, r_slice_ticks} *
                            {{tcrs_pkg::TICK_W{1'b0}}, t_rdata.prio};
                n_div_rem = '0;
                n_div_cnt = '0;
            end

            tcrs_pkg::ST_SCH_DIV: begin
                // Restoring division, one quotient bit per cycle.
                shifted   = {r_div_rem, r_dq[tcrs_pkg::PROD_W-1]};
                ge        = shifted >= {1'b0, r_prio_sum};
                if (ge) begin
                    shifted = shifted - {1'b0, r_prio_sum};
                end
                n_div_rem = shifted[tcrs_pkg::TICK_W-1:0];
                n_dq      = {r_dq[tcrs_pkg::PROD_W-2:0], ge};
                n_div_cnt = r_div_cnt + 1'b1;
            end

            tcrs_pkg::ST_SCH_WB: begin
                if (r_prio_sum == '0 || r_dq[tcrs_pkg::PROD_W-1:tcrs_pkg::TICK_W] != '0) begin
                    quo = tcrs_pkg::SLICE_SAT;
                end else begin
                    quo = r_dq[tcrs_pkg::TICK_W-1:0];
                end
                t_we            = 1'b1;
                t_waddr         = r_tid;
                t_wdata         = {r_prio, r_cls, quo};
                n_tick_valid[r_tid] = 1'b1;
                n_res.new_slice = quo;
            end

            tcrs_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end

            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tcrs_pkg::ST_IDLE;
            r_prio_sum    <= tcrs_pkg::PRIO_SUM_RST;
            r_slice_ticks <= tcrs_pkg::SLICE_TICKS_RST;
            r_head        <= '{default: '0};
            r_count       <= '{default: '0};
            r_swap        <= '0;
            r_sel_ctr     <= '0;
            r_idle_req    <= 1'b0;
            r_cur_task    <= '0;
            r_cur_queued  <= 1'b0;
            r_cur_idle    <= 1'b1;
            r_cur_rt      <= 1'b0;
            r_tick_valid  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_prio_sum    <= n_prio_sum;
            r_slice_ticks <= n_slice_ticks;
            r_head        <= n_head;
            r_count       <= n_count;
            r_swap        <= n_swap;
            r_sel_ctr     <= n_sel_ctr;
            r_idle_req    <= n_idle_req;
            r_cur_task    <= n_cur_task;
            r_cur_queued  <= n_cur_queued;
            r_cur_idle    <= n_cur_idle;
            r_cur_rt      <= n_cur_rt;
            r_tick_valid  <= n_tick_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload, no reset needed. The tick valid bit follows the table read.
    assign n_rd_valid = r_tick_valid[t_raddr];

    always_ff @(posedge i_clk) begin
        r_rd_valid <= n_rd_valid;
        r_rem      <= n_rem;
        r_exited   <= n_exited;
        r_proc     <= n_proc;
        r_rt_pick  <= n_rt_pick;
        r_tid      <= n_tid;
        r_prio     <= n_prio;
        r_cls      <= n_cls;
        r_div_rem  <= n_div_rem;
        r_dq       <= n_dq;
        r_div_cnt  <= n_div_cnt;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule
